// ===== rtl/core/ect_pkg.sv =====
`default_nettype none
package ect_pkg;

  // Token queue depth between front and back
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] SAT16    = 16'hFFFF;
  localparam logic [2:0]  KW_MATCH = 3'd5;
  localparam logic [2:0]  KW_FAIL  = 3'd6;

  // Character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // Token kinds
  localparam logic [3:0] K_INT     = 4'd0;
  localparam logic [3:0] K_FLOAT   = 4'd1;
  localparam logic [3:0] K_IDENT   = 4'd2;
  localparam logic [3:0] K_PRINT   = 4'd3;
  localparam logic [3:0] K_SPACE   = 4'd4;
  localparam logic [3:0] K_LPAR    = 4'd5;
  localparam logic [3:0] K_RPAR    = 4'd6;
  localparam logic [3:0] K_PLUS    = 4'd7;
  localparam logic [3:0] K_MINUS   = 4'd8;
  localparam logic [3:0] K_STAR    = 4'd9;
  localparam logic [3:0] K_SLASH   = 4'd10;
  localparam logic [3:0] K_COLON   = 4'd11;
  localparam logic [3:0] K_EQ      = 4'd12;
  localparam logic [3:0] K_ARROW   = 4'd13;
  localparam logic [3:0] K_UNKNOWN = 4'd14;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_NUM   = 5'b00010,
    MODE_WORD  = 5'b00100,
    MODE_BLANK = 5'b01000,
    MODE_MINUS = 5'b10000
  } scan_mode_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] length;
    logic        last;
  } token_t;

  // Up to two tokens from one character, first one first
  typedef struct packed {
    logic   a_valid;
    token_t a;
    logic   b_valid;
    token_t b;
  } token_pair_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_FF) || (c == CH_VT);
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  // Expected character of the keyword at a given match position
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h70;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h69;
      3'd3:    ch = 8'h6E;
      3'd4:    ch = 8'h74;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] single_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LPAR:  k = K_LPAR;
      CH_RPAR:  k = K_RPAR;
      CH_PLUS:  k = K_PLUS;
      CH_MINUS: k = K_MINUS;
      CH_STAR:  k = K_STAR;
      CH_SLASH: k = K_SLASH;
      CH_COLON: k = K_COLON;
      CH_EQ:    k = K_EQ;
      default:  k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  // Kind of the open run for a given mode
  function automatic logic [3:0] run_kind(input scan_mode_t m, input logic dot,
                                          input logic [2:0] kw);
    logic [3:0] k;
    case (m)
      MODE_NUM:   k = dot ? K_FLOAT : K_INT;
      MODE_WORD:  k = (kw == KW_MATCH) ? K_PRINT : K_IDENT;
      MODE_BLANK: k = K_SPACE;
      MODE_MINUS: k = K_MINUS;
      default:    k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/expression_char_tokenizer.sv =====
`default_nettype none
// Character tokenizer for expression source lines. One character enters per cycle on the
// slave stream; the tokens it closes leave on the master stream, one per cycle while m_tready
// is high, with kind, line, start column, saturating length and a last-token flag. The front
// takes a character whenever the token queue (QueueDepth entries) has room for two tokens;
// the back drains one token per cycle, as the output takes them, through an output register.
// A character yields at most two tokens, so input flows at one character per cycle as long as
// the output keeps taking tokens and the text averages no more than one token per character.
// A closing character's token is written into the queue and then held in the output register.
module expression_char_tokenizer #(
  parameter int QueueDepth = ect_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,  // [7:0] char_code, [23:8] line_number
  input  wire         s_tlast,  // end_of_string
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [55:0] m_tdata,  // [3:0] token_kind, [19:4] token_line,
                                // [35:20] token_column, [51:36] token_length, zeros above
  output logic        m_tlast   // last_token
);

  ect_pkg::token_pair_t push;
  ect_pkg::token_t      head;
  ect_pkg::token_t      out_tok;
  logic                 room;
  logic                 head_valid;
  logic                 pop;
  logic                 fire;

  assign s_tready = room;
  assign fire     = s_tvalid && room;

  ect_front u_front (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .char_code     (s_tdata[7:0]),
    .line_number   (s_tdata[23:8]),
    .end_of_string (s_tlast),
    .push          (push)
  );

  ect_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop        (pop),
    .room       (room),
    .head_valid (head_valid),
    .head       (head)
  );

  ect_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_tok    (out_tok)
  );

  // Pack the result word
  assign m_tdata = {4'b0000, out_tok.length, out_tok.column, out_tok.line, out_tok.kind};
  assign m_tlast = out_tok.last;

  // No token pushed without an accepted character
  assert property (@(posedge clk) disable iff (rst)
    (push.a_valid || push.b_valid) |-> (s_tvalid && s_tready))
    else $error("token pushed without accepted character");

  // Second slot only used alongside the first
  assert property (@(posedge clk) disable iff (rst)
    push.b_valid |-> push.a_valid)
    else $error("second token pushed alone");

  // Every delivered token has a nonzero length
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_tok.length != 16'd0))
    else $error("zero-length token");

  // Arrows are always two characters long
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_tok.kind == ect_pkg::K_ARROW)) |-> (out_tok.length == 16'd2))
    else $error("arrow token with wrong length");

  // Popping only happens with a token in the queue
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/ect_front.sv =====
`default_nettype none
module ect_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  fire,
  input  wire  [7:0]           char_code,
  input  wire  [15:0]          line_number,
  input  wire                  end_of_string,
  output ect_pkg::token_pair_t push
);

  ect_pkg::scan_mode_t mode, mode_next;
  logic        seen_dot, seen_dot_next;
  logic [2:0]  kw, kw_next;
  logic [15:0] start_col, start_col_next;
  logic [15:0] run_len, run_len_next;
  logic [15:0] open_line, open_line_next;
  logic [15:0] pos;
  logic        cont;
  logic        start;
  ect_pkg::token_t tok_a, tok_b;
  logic        a_valid, b_valid;

  // Does this character extend the open run
  always_comb begin
    case (mode)
      ect_pkg::MODE_NUM:   cont = ect_pkg::is_digit(char_code) || (char_code == ect_pkg::CH_DOT);
      ect_pkg::MODE_WORD:  cont = ect_pkg::is_letter(char_code) ||
                                  (char_code == ect_pkg::CH_UNDER);
      ect_pkg::MODE_BLANK: cont = ect_pkg::is_blank(char_code);
      default:             cont = 1'b0;
    endcase
  end

  // Classify the character against the open run
  always_comb begin
    mode_next      = mode;
    seen_dot_next  = seen_dot;
    kw_next        = kw;
    start_col_next = start_col;
    run_len_next   = run_len;
    open_line_next = open_line;
    tok_a          = '0;
    tok_b          = '0;
    a_valid        = 1'b0;
    b_valid        = 1'b0;
    start          = 1'b0;

    case (mode)
      ect_pkg::MODE_MINUS: begin
        if (char_code == ect_pkg::CH_GT) begin
          a_valid   = 1'b1;
          tok_a     = '{ect_pkg::K_ARROW, open_line, start_col, 16'd2, end_of_string};
          mode_next = ect_pkg::MODE_IDLE;
        end else begin
          a_valid = 1'b1;
          tok_a   = '{ect_pkg::K_MINUS, open_line, start_col, run_len, 1'b0};
          start   = 1'b1;
        end
      end
      ect_pkg::MODE_NUM, ect_pkg::MODE_WORD, ect_pkg::MODE_BLANK: begin
        if (cont) begin
          if ((mode == ect_pkg::MODE_NUM) && (char_code == ect_pkg::CH_DOT)) begin
            seen_dot_next = 1'b1;
          end
          if (mode == ect_pkg::MODE_WORD) begin
            if ((kw < ect_pkg::KW_MATCH) && (char_code == ect_pkg::kw_char(kw))) begin
              kw_next = kw + 3'd1;
            end else begin
              kw_next = ect_pkg::KW_FAIL;
            end
          end
          run_len_next = ect_pkg::sat_inc(run_len);
          if (end_of_string) begin
            a_valid   = 1'b1;
            tok_a     = '{ect_pkg::run_kind(mode, seen_dot_next, kw_next), open_line,
                          start_col, run_len_next, 1'b1};
            mode_next = ect_pkg::MODE_IDLE;
          end
        end else begin
          a_valid = 1'b1;
          tok_a   = '{ect_pkg::run_kind(mode, seen_dot, kw), open_line, start_col,
                      run_len, 1'b0};
          start   = 1'b1;
        end
      end
      default: begin
        start = 1'b1;
      end
    endcase

    // Open a new run, or emit a one-character token
    if (start) begin
      start_col_next = pos;
      run_len_next   = 16'd1;
      open_line_next = line_number;
      if (ect_pkg::is_digit(char_code)) begin
        mode_next     = ect_pkg::MODE_NUM;
        seen_dot_next = 1'b0;
      end else if (ect_pkg::is_letter(char_code)) begin
        mode_next = ect_pkg::MODE_WORD;
        kw_next   = (char_code == ect_pkg::kw_char(3'd0)) ? 3'd1 : ect_pkg::KW_FAIL;
      end else if (ect_pkg::is_blank(char_code)) begin
        mode_next = ect_pkg::MODE_BLANK;
      end else if (char_code == ect_pkg::CH_MINUS) begin
        mode_next = ect_pkg::MODE_MINUS;
      end else begin
        mode_next      = ect_pkg::MODE_IDLE;
        start_col_next = start_col;
        run_len_next   = run_len;
        open_line_next = open_line;
        b_valid        = 1'b1;
        tok_b          = '{ect_pkg::single_kind(char_code), line_number, pos, 16'd1,
                           end_of_string};
      end
      // A run opened by the last character closes at once
      if ((mode_next != ect_pkg::MODE_IDLE) && end_of_string) begin
        b_valid   = 1'b1;
        tok_b     = '{ect_pkg::run_kind(mode_next, seen_dot_next, kw_next), line_number,
                      pos, 16'd1, 1'b1};
        mode_next = ect_pkg::MODE_IDLE;
      end
    end
  end

  // Hand the tokens to the queue, compacted to the low slot
  always_comb begin
    push.a_valid = fire && (a_valid || b_valid);
    push.a       = a_valid ? tok_a : tok_b;
    push.b_valid = fire && a_valid && b_valid;
    push.b       = tok_b;
  end

  // Advance scan state on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ect_pkg::MODE_IDLE;
      seen_dot  <= 1'b0;
      kw        <= 3'd0;
      start_col <= 16'd0;
      run_len   <= 16'd0;
      open_line <= 16'd0;
      pos       <= 16'd0;
    end else if (fire) begin
      mode      <= mode_next;
      seen_dot  <= seen_dot_next;
      kw        <= kw_next;
      start_col <= start_col_next;
      run_len   <= run_len_next;
      open_line <= open_line_next;
      pos       <= end_of_string ? 16'd0 : ect_pkg::sat_inc(pos);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ect_queue.sv =====
`default_nettype none
module ect_queue #(
  parameter int Depth = ect_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  ect_pkg::token_pair_t push,
  input  wire                  pop,
  output logic                 room,
  output logic                 head_valid,
  output ect_pkg::token_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ect_pkg::token_t entries [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr, wr_ptr1;
  logic [CntW-1:0] count;
  logic [1:0]      n_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_ptr1    = ptr_inc(wr_ptr);
  assign n_push     = {1'b0, push.a_valid} + {1'b0, push.b_valid};
  // Room for two tokens, so one character never overflows the queue
  assign room       = (count <= CntW'(Depth - 2));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Store tokens
  always_ff @(posedge clk) begin
    if (push.a_valid) begin
      entries[wr_ptr] <= push.a;
    end
    if (push.b_valid) begin
      entries[wr_ptr1] <= push.b;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.b_valid) begin
        wr_ptr <= ptr_inc(wr_ptr1);
      end else if (push.a_valid) begin
        wr_ptr <= wr_ptr1;
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CntW'(n_push) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ect_back.sv =====
`default_nettype none
module ect_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              head_valid,
  input  ect_pkg::token_t  head,
  output logic             pop,
  output logic             out_valid,
  input  wire              out_ready,
  output ect_pkg::token_t  out_tok
);

  // Load the output register when empty or being taken
  assign pop = head_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= head_valid;
    end
  end

  // Hold the token while stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      out_tok <= head;
    end
  end

endmodule
`default_nettype wire
